### src/rrj_pkg.sv
// Shared types, constants and helper functions of the reprojection residual and Jacobian block.
`default_nettype none
package rrj_pkg;

	// Divider geometry: numerator and denominator widths, quotient bits kept.
	localparam int NUM_W   = 96;
	localparam int DEN_W   = 62;
	localparam int QB      = 51;
	localparam int DIV_LAT = QB + 2;
	localparam int N_QUOT  = 12;

	// Quotient magnitudes are clamped to this value.
	localparam logic [QB-1:0] Q_LIMIT = QB'(51'h4_0000_0000_0000);

	localparam int OUT_W     = 48;
	localparam int ACC_W     = 54;
	localparam int CFG_IDX_W = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FOCAL_X  = 4'd0,
		CFG_FOCAL_Y  = 4'd1,
		CFG_CENTER_X = 4'd2,
		CFG_CENTER_Y = 4'd3
	} cfg_idx_t;

	// Per-point values that travel alongside the dividers.
	typedef struct packed {
		logic        nx;
		logic        ny;
		logic [31:0] ou;
		logic [31:0] ov;
	} side_t;

	// One result beat.
	typedef struct packed {
		logic [OUT_W-1:0] residual_u;
		logic [OUT_W-1:0] residual_v;
		logic [OUT_W-1:0] jac_u_tx;
		logic [OUT_W-1:0] jac_u_tz;
		logic [OUT_W-1:0] jac_u_rx;
		logic [OUT_W-1:0] jac_u_ry;
		logic [OUT_W-1:0] jac_u_rz;
		logic [OUT_W-1:0] jac_v_ty;
		logic [OUT_W-1:0] jac_v_tz;
		logic [OUT_W-1:0] jac_v_rx;
		logic [OUT_W-1:0] jac_v_ry;
		logic [OUT_W-1:0] jac_v_rz;
	} res_t;

	// Applies a sign to a clamped quotient magnitude.
	function automatic logic signed [ACC_W-1:0] signed_q(input logic [QB-1:0] m,
		input logic neg);
		logic signed [ACC_W-1:0] v;
		v = $signed({{(ACC_W-QB){1'b0}}, m});
		return neg ? -v : v;
	endfunction

	// Saturates a wide signed sum to the output range.
	function automatic logic [OUT_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = $signed({{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}});
		lo = -hi - 1;
		if (v > hi)
			return hi[OUT_W-1:0];
		else if (v < lo)
			return lo[OUT_W-1:0];
		else
			return v[OUT_W-1:0];
	endfunction

endpackage
`default_nettype wire

### src/rrj_div.sv
// Pipelined restoring divider with round-half-away rounding and magnitude clamp.
`default_nettype none
module rrj_div
	import rrj_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic      [QB-1:0]    mag
);

	localparam int HI_W = NUM_W - QB;

	logic [DEN_W-1:0] rem_s [0:QB];
	logic [DEN_W-1:0] den_s [0:QB];
	logic [QB-1:0]    low_s [0:QB-1];
	logic [QB-1:0]    q_s   [0:QB];
	logic             ovf_s [0:QB];
	logic [QB-1:0]    mag_q;
	logic             top_ge;
	logic             rnd;
	logic [QB:0]      qr;
	logic             clamp;

	// The upper numerator bits decide at once whether the quotient is too large.
	assign top_ge = {{(DEN_W-HI_W){1'b0}}, num[NUM_W-1:QB]} >= den;

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= top_ge;
			rem_s[0] <= DEN_W'(num[NUM_W-1:QB]);
			low_s[0] <= num[QB-1:0];
			q_s[0]   <= '0;
			den_s[0] <= den;
		end
	end

	// One quotient bit per stage.
	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [DEN_W:0] t;
		logic [DEN_W:0] dif;
		logic           ge;

		assign t   = {rem_s[k], low_s[k][QB-1]};
		assign dif = t - {1'b0, den_s[k]};
		assign ge  = t >= {1'b0, den_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? dif[DEN_W-1:0] : t[DEN_W-1:0];
				q_s[k+1]   <= {q_s[k][QB-2:0], ge};
				den_s[k+1] <= den_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end

		if (k < QB - 1) begin : g_low
			always_ff @(posedge clk) begin
				if (en) begin
					low_s[k+1] <= {low_s[k][QB-2:0], 1'b0};
				end
			end
		end
	end

	// Round on the remainder, then clamp.
	assign rnd   = {rem_s[QB], 1'b0} >= {1'b0, den_s[QB]};
	assign qr    = {1'b0, q_s[QB]} + (QB+1)'(rnd);
	assign clamp = ovf_s[QB] || (qr > {1'b0, Q_LIMIT});

	always_ff @(posedge clk) begin
		if (en) begin
			mag_q <= clamp ? Q_LIMIT : qr[QB-1:0];
		end
	end

	assign mag = mag_q;

endmodule
`default_nettype wire

### src/reprojection_residual_jacobian.sv
// Top level: pinhole reprojection residual and SE(3) Jacobian, one point per beat.
// Throughput is one point per cycle while in_stall is low; the depth is set
// by the 51 one-bit divider stages.
// A one-beat skid buffer after the output register lets the pipeline drain one beat.
// Reset clears all valid bits and loads the default camera registers; no clearing pass.
`default_nettype none
module reprojection_residual_jacobian
	import rrj_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [31:0]          point_x,
	input  wire logic [31:0]          point_y,
	input  wire logic [30:0]          point_z,
	input  wire logic [31:0]          observed_u,
	input  wire logic [31:0]          observed_v,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [OUT_W-1:0]          residual_u,
	output logic [OUT_W-1:0]          residual_v,
	output logic [OUT_W-1:0]          jac_u_tx,
	output logic [OUT_W-1:0]          jac_u_tz,
	output logic [OUT_W-1:0]          jac_u_rx,
	output logic [OUT_W-1:0]          jac_u_ry,
	output logic [OUT_W-1:0]          jac_u_rz,
	output logic [OUT_W-1:0]          jac_v_ty,
	output logic [OUT_W-1:0]          jac_v_tz,
	output logic [OUT_W-1:0]          jac_v_rx,
	output logic [OUT_W-1:0]          jac_v_ry,
	output logic [OUT_W-1:0]          jac_v_rz
);

	logic [31:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
	logic        en;

	// Camera registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= 32'd32768000;
			focal_y_q  <= 32'd32768000;
			center_x_q <= 32'd20971520;
			center_y_q <= 32'd15728640;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FOCAL_X:  focal_x_q  <= cfg_data;
				CFG_FOCAL_Y:  focal_y_q  <= cfg_data;
				CFG_CENTER_X: center_x_q <= cfg_data;
				CFG_CENTER_Y: center_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: input registers.
	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [31:0] x_s1, y_s1, ou_s1, ov_s1;
	logic [30:0] z_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= point_x;
			y_s1  <= point_y;
			z_s1  <= point_z;
			ou_s1 <= observed_u;
			ov_s1 <= observed_v;
		end
	end

	// Stage 2: magnitudes, signs and the depth with zero taken as one.
	logic [31:0] ax_s2, ay_s2;
	logic [30:0] zz_s2;
	side_t       side_s2, side_s3, side_s4, side_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s2      <= x_s1[31] ? (32'd0 - x_s1) : x_s1;
			ay_s2      <= y_s1[31] ? (32'd0 - y_s1) : y_s1;
			zz_s2      <= (z_s1 == 31'd0) ? 31'd1 : z_s1;
			side_s2.nx <= x_s1[31];
			side_s2.ny <= y_s1[31];
			side_s2.ou <= ou_s1;
			side_s2.ov <= ov_s1;
		end
	end

	// Stage 3: focal products and the squared depth.
	logic [63:0] fxx_s3, fxy_s3, fyx_s3, fyy_s3;
	logic [61:0] z2_s3;
	logic [31:0] ax_s3, ay_s3;
	logic [30:0] zz_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			fxx_s3  <= {32'd0, focal_x_q} * {32'd0, ax_s2};
			fxy_s3  <= {32'd0, focal_x_q} * {32'd0, ay_s2};
			fyx_s3  <= {32'd0, focal_y_q} * {32'd0, ax_s2};
			fyy_s3  <= {32'd0, focal_y_q} * {32'd0, ay_s2};
			z2_s3   <= {31'd0, zz_s2} * {31'd0, zz_s2};
			ax_s3   <= ax_s2;
			ay_s3   <= ay_s2;
			zz_s3   <= zz_s2;
			side_s3 <= side_s2;
		end
	end

	// Stage 4: partial products of the second-order numerators.
	logic [63:0] xay_lo_s4, xay_hi_s4, xax_lo_s4, xax_hi_s4;
	logic [63:0] yay_lo_s4, yay_hi_s4, yxy_lo_s4, yxy_hi_s4;
	logic [63:0] fxx_s4, fxy_s4, fyx_s4, fyy_s4;
	logic [61:0] z2_s4;
	logic [30:0] zz_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			xay_lo_s4 <= {32'd0, fxx_s3[31:0]}  * {32'd0, ay_s3};
			xay_hi_s4 <= {32'd0, fxx_s3[63:32]} * {32'd0, ay_s3};
			xax_lo_s4 <= {32'd0, fxx_s3[31:0]}  * {32'd0, ax_s3};
			xax_hi_s4 <= {32'd0, fxx_s3[63:32]} * {32'd0, ax_s3};
			yay_lo_s4 <= {32'd0, fyy_s3[31:0]}  * {32'd0, ay_s3};
			yay_hi_s4 <= {32'd0, fyy_s3[63:32]} * {32'd0, ay_s3};
			yxy_lo_s4 <= {32'd0, fyx_s3[31:0]}  * {32'd0, ay_s3};
			yxy_hi_s4 <= {32'd0, fyx_s3[63:32]} * {32'd0, ay_s3};
			fxx_s4    <= fxx_s3;
			fxy_s4    <= fxy_s3;
			fyx_s4    <= fyx_s3;
			fyy_s4    <= fyy_s3;
			z2_s4     <= z2_s3;
			zz_s4     <= zz_s3;
			side_s4   <= side_s3;
		end
	end

	// Stage 5: full numerators and denominators for the twelve quotients.
	logic [NUM_W-1:0] num_s5 [0:N_QUOT-1];
	logic [DEN_W-1:0] den_z_s5, den_z2_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s5[0]  <= NUM_W'(fxx_s4);
			num_s5[1]  <= NUM_W'(fyy_s4);
			num_s5[2]  <= NUM_W'({focal_x_q, 16'd0});
			num_s5[3]  <= NUM_W'({fxx_s4, 16'd0});
			num_s5[4]  <= {xay_hi_s4, 32'd0} + {32'd0, xay_lo_s4};
			num_s5[5]  <= {xax_hi_s4, 32'd0} + {32'd0, xax_lo_s4};
			num_s5[6]  <= NUM_W'(fxy_s4);
			num_s5[7]  <= NUM_W'({focal_y_q, 16'd0});
			num_s5[8]  <= NUM_W'({fyy_s4, 16'd0});
			num_s5[9]  <= {yay_hi_s4, 32'd0} + {32'd0, yay_lo_s4};
			num_s5[10] <= {yxy_hi_s4, 32'd0} + {32'd0, yxy_lo_s4};
			num_s5[11] <= NUM_W'(fyx_s4);
			den_z_s5   <= DEN_W'(zz_s4);
			den_z2_s5  <= z2_s4;
			side_s5    <= side_s4;
		end
	end

	// Dividers: depth for first-order terms, squared depth for the rest.
	logic [QB-1:0] mag_w [0:N_QUOT-1];

	for (genvar i = 0; i < N_QUOT; i++) begin : g_div
		localparam bit BY_Z = (i == 0) || (i == 1) || (i == 2) || (i == 6) ||
			(i == 7) || (i == 11);

		rrj_div u_div (
			.clk (clk),
			.en  (en),
			.num (num_s5[i]),
			.den (BY_Z ? den_z_s5 : den_z2_s5),
			.mag (mag_w[i])
		);
	end

	// Side values and valid bits follow the dividers.
	side_t              side_d [0:DIV_LAT-1];
	logic [DIV_LAT-1:0] vld_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_d <= '0;
		end else if (en) begin
			vld_d <= {vld_d[DIV_LAT-2:0], vld_s5};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_d[0] <= side_s5;
			for (int k = 1; k < DIV_LAT; k++) begin
				side_d[k] <= side_d[k-1];
			end
		end
	end

	// Final stage: signs, offsets and saturation.
	side_t                   sd;
	logic signed [ACC_W-1:0] qv [0:N_QUOT-1];
	logic signed [ACC_W-1:0] fx_w, fy_w, cx_w, cy_w, ou_w, ov_w;
	res_t                    res_c;
	res_t                    res_sf;
	logic                    vld_sf;

	assign sd   = side_d[DIV_LAT-1];
	assign fx_w = $signed({{(ACC_W-32){1'b0}}, focal_x_q});
	assign fy_w = $signed({{(ACC_W-32){1'b0}}, focal_y_q});
	assign cx_w = ACC_W'($signed(center_x_q));
	assign cy_w = ACC_W'($signed(center_y_q));
	assign ou_w = ACC_W'($signed(sd.ou));
	assign ov_w = ACC_W'($signed(sd.ov));

	assign qv[0]  = signed_q(mag_w[0], sd.nx);
	assign qv[1]  = signed_q(mag_w[1], sd.ny);
	assign qv[2]  = signed_q(mag_w[2], 1'b1);
	assign qv[3]  = signed_q(mag_w[3], sd.nx);
	assign qv[4]  = signed_q(mag_w[4], sd.nx != sd.ny);
	assign qv[5]  = signed_q(mag_w[5], 1'b0);
	assign qv[6]  = signed_q(mag_w[6], sd.ny);
	assign qv[7]  = signed_q(mag_w[7], 1'b1);
	assign qv[8]  = signed_q(mag_w[8], sd.ny);
	assign qv[9]  = signed_q(mag_w[9], 1'b0);
	assign qv[10] = signed_q(mag_w[10], sd.nx == sd.ny);
	assign qv[11] = signed_q(mag_w[11], !sd.nx);

	always_comb begin
		res_c.residual_u = sat48(ou_w - (qv[0] + cx_w));
		res_c.residual_v = sat48(ov_w - (qv[1] + cy_w));
		res_c.jac_u_tx   = sat48(qv[2]);
		res_c.jac_u_tz   = sat48(qv[3]);
		res_c.jac_u_rx   = sat48(qv[4]);
		res_c.jac_u_ry   = sat48(-fx_w - qv[5]);
		res_c.jac_u_rz   = sat48(qv[6]);
		res_c.jac_v_ty   = sat48(qv[7]);
		res_c.jac_v_tz   = sat48(qv[8]);
		res_c.jac_v_rx   = sat48(fy_w + qv[9]);
		res_c.jac_v_ry   = sat48(qv[10]);
		res_c.jac_v_rz   = sat48(qv[11]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sf <= 1'b0;
		end else if (en) begin
			vld_sf <= vld_d[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_sf <= res_c;
		end
	end

	// Output register with a one-beat skid buffer behind it.
	res_t res_q, skid_q;
	logic out_valid_q, skid_vld_q;

	assign en       = !skid_vld_q;
	assign in_stall = skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_vld_q  <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= skid_vld_q || vld_sf;
			skid_vld_q  <= 1'b0;
		end else if (en && vld_sf) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			res_q <= skid_vld_q ? skid_q : res_sf;
		end else if (en && vld_sf) begin
			skid_q <= res_sf;
		end
	end

	assign out_valid  = out_valid_q;
	assign residual_u = res_q.residual_u;
	assign residual_v = res_q.residual_v;
	assign jac_u_tx   = res_q.jac_u_tx;
	assign jac_u_tz   = res_q.jac_u_tz;
	assign jac_u_rx   = res_q.jac_u_rx;
	assign jac_u_ry   = res_q.jac_u_ry;
	assign jac_u_rz   = res_q.jac_u_rz;
	assign jac_v_ty   = res_q.jac_v_ty;
	assign jac_v_tz   = res_q.jac_v_tz;
	assign jac_v_rx   = res_q.jac_v_rx;
	assign jac_v_ry   = res_q.jac_v_ry;
	assign jac_v_rz   = res_q.jac_v_rz;

	// A held skid beat always sits behind a valid output beat.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_valid_q)
		else $error("skid beat without output beat");

	// While the pipeline is frozen its entry stage and its final stage do not move.
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s1) && $stable(vld_sf))
		else $error("pipeline moved while frozen");

	// The magnitudes of dividers 0 and 5 never pass the clamp.
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		vld_d[DIV_LAT-1] |-> (mag_w[0] <= Q_LIMIT) && (mag_w[5] <= Q_LIMIT))
		else $error("quotient above clamp");

endmodule
`default_nettype wire

### tb/reprojection_residual_jacobian_test.sv
// Testbench for the pinhole reprojection residual and SE(3) Jacobian block.
module reprojection_residual_jacobian_test;
	import rrj_pkg::*;

	// One input point with its observation, and an optional typed result.
	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [30:0] z;
		logic [31:0] u;
		logic [31:0] v;
		bit          typed;
		res_t        res;
	} point_row_t;

	localparam int N_ROWS = 12;
	localparam int SETTLE = 80;
	localparam logic [47:0] POS_500 = 48'h0000_01F4_0000;
	localparam logic [47:0] NEG_500 = 48'hFFFF_FE0C_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] point_x = '0, point_y = '0, observed_u = '0, observed_v = '0;
	logic [30:0] point_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [OUT_W-1:0] residual_u, residual_v, jac_u_tx, jac_u_tz, jac_u_rx, jac_u_ry;
	logic [OUT_W-1:0] jac_u_rz, jac_v_ty, jac_v_tz, jac_v_rx, jac_v_ry, jac_v_rz;
	res_t got;

	// Camera registers as the block should hold them.
	logic [31:0] cam_fx, cam_fy, cam_cx, cam_cy;

	res_t expected_results[$];
	int n_points = 0, n_results = 0, n_errors = 0, n_cfg = 0;
	bit quiet = 1'b0;
	point_row_t directed[N_ROWS];

	reprojection_residual_jacobian DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.observed_u(observed_u), .observed_v(observed_v),
		.out_valid(out_valid), .out_stall(out_stall),
		.residual_u(residual_u), .residual_v(residual_v),
		.jac_u_tx(jac_u_tx), .jac_u_tz(jac_u_tz), .jac_u_rx(jac_u_rx),
		.jac_u_ry(jac_u_ry), .jac_u_rz(jac_u_rz),
		.jac_v_ty(jac_v_ty), .jac_v_tz(jac_v_tz), .jac_v_rx(jac_v_rx),
		.jac_v_ry(jac_v_ry), .jac_v_rz(jac_v_rz)
	);

	// The result beat gathered in field order.
	assign got = {residual_u, residual_v, jac_u_tx, jac_u_tz, jac_u_rx, jac_u_ry,
		jac_u_rz, jac_v_ty, jac_v_tz, jac_v_rx, jac_v_ry, jac_v_rz};

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Rounded a*b/den, halves away from zero, magnitude clamped to 2^50.
	function automatic longint round_quot(input logic [63:0] a, input logic [63:0] b,
		input logic [63:0] den, input bit neg);
		logic [127:0] num, q, r;
		num = {64'b0, a} * {64'b0, b};
		q = num / den;
		r = num % den;
		if (r >= den - r)
			q = q + 128'd1;
		if (q > (128'd1 << 50))
			q = 128'd1 << 50;
		return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	function automatic logic [47:0] clamp48(input longint v);
		if (v > 64'sh7FFF_FFFF_FFFF)
			return 48'h7FFF_FFFF_FFFF;
		if (v < -64'sh8000_0000_0000)
			return 48'h8000_0000_0000;
		return v[47:0];
	endfunction

	// Residual and Jacobian of one point under the current camera registers.
	function automatic res_t project_point(input logic [31:0] x, input logic [31:0] y,
		input logic [30:0] z, input logic [31:0] u, input logic [31:0] v);
		res_t r;
		longint sx, sy, cx, cy, fx, fy;
		logic [63:0] ax, ay, zz, z2, fxx, fxy, fyx, fyy;
		bit nx, ny;
		sx = longint'($signed(x));
		sy = longint'($signed(y));
		cx = longint'($signed(cam_cx));
		cy = longint'($signed(cam_cy));
		fx = longint'({32'b0, cam_fx});
		fy = longint'({32'b0, cam_fy});
		nx = sx < 0;
		ny = sy < 0;
		ax = nx ? -sx : sx;
		ay = ny ? -sy : sy;
		// Zero depth behaves as the smallest positive depth.
		zz = (z == 0) ? 64'd1 : {33'b0, z};
		z2 = zz * zz;
		fxx = {32'b0, cam_fx} * ax;
		fxy = {32'b0, cam_fx} * ay;
		fyx = {32'b0, cam_fy} * ax;
		fyy = {32'b0, cam_fy} * ay;
		r.residual_u = clamp48(longint'($signed(u)) - (round_quot(fxx, 64'd1, zz, nx) + cx));
		r.residual_v = clamp48(longint'($signed(v)) - (round_quot(fyy, 64'd1, zz, ny) + cy));
		r.jac_u_tx = clamp48(round_quot({32'b0, cam_fx}, 64'd65536, zz, 1'b1));
		r.jac_u_tz = clamp48(round_quot(fxx, 64'd65536, z2, nx));
		r.jac_u_rx = clamp48(round_quot(fxx, ay, z2, nx != ny));
		r.jac_u_ry = clamp48(-fx - round_quot(fxx, ax, z2, 1'b0));
		r.jac_u_rz = clamp48(round_quot(fxy, 64'd1, zz, ny));
		r.jac_v_ty = clamp48(round_quot({32'b0, cam_fy}, 64'd65536, zz, 1'b1));
		r.jac_v_tz = clamp48(round_quot(fyy, 64'd65536, z2, ny));
		r.jac_v_rx = clamp48(fy + round_quot(fyy, ay, z2, 1'b0));
		r.jac_v_ry = clamp48(round_quot(fyx, ay, z2, nx == ny));
		r.jac_v_rz = clamp48(round_quot(fyx, 64'd1, zz, !nx));
		return r;
	endfunction

	// Random hold-off burst of the sending side.
	task automatic sender_gap();
		int n;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Presents one point and returns at the edge that accepts it.
	task automatic send_point(input point_row_t p);
		sender_gap();
		in_valid <= 1'b1;
		point_x <= p.x;
		point_y <= p.y;
		point_z <= p.z;
		observed_u <= p.u;
		observed_v <= p.v;
		expected_results.push_back(p.typed ? p.res : project_point(p.x, p.y, p.z, p.u, p.v));
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		n_points++;
	endtask

	// Register write; only called when the pipeline is empty.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_FOCAL_X: cam_fx = data;
			CFG_FOCAL_Y: cam_fy = data;
			CFG_CENTER_X: cam_cx = data;
			CFG_CENTER_Y: cam_cy = data;
			default: ;
		endcase
		n_cfg++;
		@(posedge clk);
	endtask

	// Hold the sender until every result is back and the pipeline has emptied.
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Mostly plausible scene points, with some unconstrained bit patterns.
	function automatic point_row_t random_point();
		point_row_t p;
		p.typed = 1'b0;
		p.res = '0;
		if ($urandom_range(0, 7) == 0) begin
			p.x = $urandom;
			p.y = $urandom;
			p.z = 31'($urandom);
			p.u = $urandom;
			p.v = $urandom;
		end else begin
			p.x = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
			p.y = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
			p.z = 31'($urandom_range(32'h0000_4000, 32'h0400_0000));
			p.u = $urandom_range(0, 32'h0300_0000);
			p.v = $urandom_range(0, 32'h0200_0000);
		end
		return p;
	endfunction

	// Output side: random stall bursts, none in the closing stretch.
	int stall_left = 0;
	always @(posedge clk) begin
		if (quiet) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 13);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Result checker: a beat sampled here is taken at the coming edge.
	string field_name[12] = '{"residual_u", "residual_v", "jac_u_tx", "jac_u_tz",
		"jac_u_rx", "jac_u_ry", "jac_u_rz", "jac_v_ty", "jac_v_tz", "jac_v_rx",
		"jac_v_ry", "jac_v_rz"};
	always @(negedge clk) begin
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result beat", $time);
				n_errors++;
			end else begin
				want = expected_results.pop_front();
				for (int i = 0; i < 12; i++)
					if (want[575 - 48 * i -: 48] !== got[575 - 48 * i -: 48]) begin
						$display("%0t: %s expected %h actual %h", $time, field_name[i],
							want[575 - 48 * i -: 48], got[575 - 48 * i -: 48]);
						n_errors++;
					end
				n_results++;
			end
		end
	end

	initial begin
		#4000000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		point_row_t p;
		res_t origin;
		cam_fx = 32'd32768000;
		cam_fy = 32'd32768000;
		cam_cx = 32'd20971520;
		cam_cy = 32'd15728640;

		// A point on the optical axis at unit depth, seen at the principal point.
		origin = '0;
		origin.jac_u_tx = NEG_500;
		origin.jac_u_ry = NEG_500;
		origin.jac_v_ty = NEG_500;
		origin.jac_v_rx = POS_500;
		directed = '{
			'{32'h0, 32'h0, 31'h1_0000, 32'h0140_0000, 32'h00F0_0000, 1'b1, origin},
			'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0},
			'{32'h8000_0000, 32'h8000_0000, 31'h1, 32'h8000_0000, 32'h8000_0000, 1'b0, '0},
			'{32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, '0},
			'{32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h1, 1'b0, '0},
			'{32'h1_0000, 32'hFFFF_0000, 31'h2_0000, 32'h64_0000, 32'hFF9C_0000, 1'b0, '0},
			'{32'hFFFF_FFFF, 32'h1, 31'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
			'{32'h0, 32'h7FFF_FFFF, 31'h0, 32'h0, 32'h0, 1'b0, '0},
			'{32'h8000_0000, 32'h0, 31'h4000_0000, 32'h0, 32'h0, 1'b0, '0},
			'{32'h0003_0000, 32'h0002_8000, 31'h0000_8000, 32'h0140_0000, 32'h00F0_0000,
				1'b0, '0},
			'{32'hFFFE_0000, 32'hFFFD_0000, 31'h0005_0000, 32'h0, 32'h0, 1'b0, '0},
			'{32'h2AAA_AAAA, 32'hD555_5555, 31'h5555_5555, 32'h1234_5678, 32'hEDCB_A987,
				1'b0, '0}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed points under the reset camera.
		for (int i = 0; i < N_ROWS; i++)
			send_point(directed[i]);

		// Camera settings: zero focal lengths, the largest ones, the smallest,
		// then random ones; the close of the run has no idling.
		for (int phase = 0; phase < 8; phase++) begin
			drain();
			case (phase)
				0: begin
					write_reg(CFG_FOCAL_X, 32'h0);
					write_reg(CFG_FOCAL_Y, 32'h0);
					write_reg(CFG_CENTER_X, 32'h8000_0000);
					write_reg(CFG_CENTER_Y, 32'h7FFF_FFFF);
				end
				1: begin
					write_reg(CFG_FOCAL_X, 32'hFFFF_FFFF);
					write_reg(CFG_FOCAL_Y, 32'hFFFF_FFFF);
					write_reg(CFG_CENTER_X, 32'h7FFF_FFFF);
					write_reg(CFG_CENTER_Y, 32'h8000_0000);
				end
				2: begin
					write_reg(CFG_FOCAL_X, 32'h1);
					write_reg(CFG_FOCAL_Y, 32'h1);
					write_reg(CFG_CENTER_X, 32'h0);
					write_reg(CFG_CENTER_Y, 32'h0);
				end
				default: begin
					write_reg(CFG_FOCAL_X, $urandom_range(32'h0010_0000, 32'h1000_0000));
					write_reg(CFG_FOCAL_Y, $urandom_range(32'h0010_0000, 32'h1000_0000));
					write_reg(CFG_CENTER_X, $urandom);
					write_reg(CFG_CENTER_Y, $urandom_range(0, 32'h0400_0000));
				end
			endcase
			// An index outside the register map must leave the camera untouched.
			write_reg(CFG_IDX_W'($urandom_range(4, 15)), $urandom);
			if (phase < 2)
				for (int i = 0; i < N_ROWS; i++) begin
					p = directed[i];
					p.typed = 1'b0;
					send_point(p);
				end
			quiet = (phase == 7);
			for (int i = 0; i < 118; i++)
				send_point(random_point());
		end

		// Let the last results come out, then allow for the pipeline depth.
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Covered %0d points and %0d register writes over eight camera settings,",
			n_points, n_cfg);
		$display("including zero and full-scale focal lengths; %0d result beats checked.",
			n_results);
		if (n_errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
